### src/vpa_pkg.sv
// vpa_pkg: shared types and constants of the variable partition allocator
// used by vpa_fit, vpa_table and variable_partition_allocator
`default_nettype none
package vpa_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int ADDR_W     = 16;
  localparam int OWNER_W    = 8;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    OP_FIRST = 2'd0,
    OP_BEST  = 2'd1,
    OP_WORST = 2'd2,
    OP_FREE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FREE,
    S_RESULT
  } state_e;

  // one table entry
  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [ADDR_W-1:0]  size;
    logic               free;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  // one table write
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

endpackage
`default_nettype wire

### src/variable_partition_allocator.sv
// variable_partition_allocator: top level, sequencer around the block table and compare unit
// depends on vpa_pkg, vpa_fit, vpa_table
`default_nettype none
// A request takes one table entry per cycle through a single compare unit.
// Allocation scans the table (first fit stops early at the first fitting
// block), then shifts the table up when the block is split. Free makes one
// combined release and merge pass. The result is then presented and held
// until taken. A configuration write, and reset, rebuild the table in S_INIT;
// the block is busy (in_stall_o high, cfg_ready_o low) whenever it is not idle,
// and a configuration beat offered while idle takes priority over a request
// beat (in_stall_o stays high for it).
module variable_partition_allocator (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [vpa_pkg::ADDR_W-1:0]  total_memory_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [vpa_pkg::ADDR_W-1:0]  request_size_i,
  input  wire logic [vpa_pkg::OWNER_W-1:0] owner_id_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [1:0]                       status_o,
  output logic [vpa_pkg::ADDR_W-1:0]       alloc_start_o
);

  localparam logic [vpa_pkg::CNT_W-1:0] CntMax = vpa_pkg::CNT_W'(vpa_pkg::MAX_BLOCKS);

  vpa_pkg::state_e state_q, state_d;
  vpa_pkg::op_e    op_q, op_d;
  logic [vpa_pkg::ADDR_W-1:0]  total_q, total_d;
  logic [vpa_pkg::ADDR_W-1:0]  req_q, req_d;
  logic [vpa_pkg::OWNER_W-1:0] own_q, own_d;
  logic [vpa_pkg::CNT_W-1:0]   count_q, count_d;
  logic [vpa_pkg::CNT_W-1:0]   idx_q, idx_d;
  logic [vpa_pkg::CNT_W-1:0]   wr_q, wr_d;
  logic                        found_q, found_d;
  logic [vpa_pkg::IDX_W-1:0]   pick_q, pick_d;
  logic [vpa_pkg::ADDR_W-1:0]  pick_size_q, pick_size_d;
  logic [vpa_pkg::ADDR_W-1:0]  pick_start_q, pick_start_d;
  logic                        acc_vld_q, acc_vld_d;
  vpa_pkg::entry_t             acc_q, acc_d;
  vpa_pkg::status_e            res_status_q, res_status_d;
  logic [vpa_pkg::ADDR_W-1:0]  res_start_q, res_start_d;

  logic [vpa_pkg::IDX_W-1:0] rd_idx;
  vpa_pkg::entry_t           rd_data;
  vpa_pkg::tbl_wr_t          wr_a, wr_b;
  logic                      fit, better, freed;

  vpa_table u_table (
    .clk_i     (clk_i),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .wr_a_i    (wr_a),
    .wr_b_i    (wr_b)
  );

  vpa_fit u_fit (
    .op_i        (op_q),
    .entry_i     (rd_data),
    .req_i       (req_q),
    .pick_size_i (pick_size_q),
    .fit_o       (fit),
    .better_o    (better)
  );

  // a configuration beat blocks the request channel while idle
  assign in_stall_o    = (state_q != vpa_pkg::S_IDLE) || cfg_valid_i;
  assign cfg_ready_o   = (state_q == vpa_pkg::S_IDLE);
  assign out_valid_o   = (state_q == vpa_pkg::S_RESULT);
  assign status_o      = res_status_q;
  assign alloc_start_o = res_start_q;

  // entry free after a free request: already free or owned by the requester
  assign freed = rd_data.free || (rd_data.owner == own_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    total_d      = total_q;
    req_d        = req_q;
    own_d        = own_q;
    count_d      = count_q;
    idx_d        = idx_q;
    wr_d         = wr_q;
    found_d      = found_q;
    pick_d       = pick_q;
    pick_size_d  = pick_size_q;
    pick_start_d = pick_start_q;
    acc_vld_d    = acc_vld_q;
    acc_d        = acc_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    rd_idx       = idx_q[vpa_pkg::IDX_W-1:0];
    wr_a         = '0;
    wr_b         = '0;
    case (state_q)
      vpa_pkg::S_INIT: begin
        wr_a.en         = 1'b1;
        wr_a.idx        = '0;
        wr_a.data.start = '0;
        wr_a.data.size  = total_q;
        wr_a.data.free  = 1'b1;
        wr_a.data.owner = '0;
        count_d         = vpa_pkg::CNT_W'(1);
        state_d         = vpa_pkg::S_IDLE;
      end
      vpa_pkg::S_IDLE: begin
        if (cfg_valid_i) begin
          total_d = total_memory_i;
          state_d = vpa_pkg::S_INIT;
        end else if (in_valid_i) begin
          op_d      = vpa_pkg::op_e'(operation_i);
          req_d     = request_size_i;
          own_d     = owner_id_i;
          idx_d     = '0;
          wr_d      = '0;
          found_d   = 1'b0;
          acc_vld_d = 1'b0;
          state_d   = (vpa_pkg::op_e'(operation_i) == vpa_pkg::OP_FREE) ?
                      vpa_pkg::S_FREE : vpa_pkg::S_SCAN;
        end
      end
      vpa_pkg::S_SCAN: begin
        if (idx_q == count_q) begin
          res_start_d = '0;
          if (!found_q) begin
            res_status_d = vpa_pkg::ST_NOFIT;
            state_d      = vpa_pkg::S_RESULT;
          end else if (pick_size_q == req_q) begin
            wr_a.en         = 1'b1;
            wr_a.idx        = pick_q;
            wr_a.data.start = pick_start_q;
            wr_a.data.size  = req_q;
            wr_a.data.free  = 1'b0;
            wr_a.data.owner = own_q;
            res_status_d    = vpa_pkg::ST_DONE;
            res_start_d     = pick_start_q;
            state_d         = vpa_pkg::S_RESULT;
          end else if (count_q == CntMax) begin
            res_status_d = vpa_pkg::ST_FULL;
            state_d      = vpa_pkg::S_RESULT;
          end else begin
            state_d = vpa_pkg::S_SHIFT;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          if (fit && (!found_q || better)) begin
            found_d      = 1'b1;
            pick_d       = idx_q[vpa_pkg::IDX_W-1:0];
            pick_size_d  = rd_data.size;
            pick_start_d = rd_data.start;
          end
          // first fit stops at the first fitting block
          if (fit && op_q == vpa_pkg::OP_FIRST) begin
            idx_d = count_q;
          end
        end
      end
      vpa_pkg::S_SHIFT: begin
        // idx_q counts down from count_q, moving one entry up per cycle
        if (idx_q == {1'b0, pick_q} + 1'b1) begin
          wr_a.en         = 1'b1;
          wr_a.idx        = pick_q;
          wr_a.data.start = pick_start_q;
          wr_a.data.size  = req_q;
          wr_a.data.free  = 1'b0;
          wr_a.data.owner = own_q;
          wr_b.en         = 1'b1;
          wr_b.idx        = pick_q + 1'b1;
          wr_b.data.start = pick_start_q + req_q;
          wr_b.data.size  = pick_size_q - req_q;
          wr_b.data.free  = 1'b1;
          wr_b.data.owner = '0;
          count_d         = count_q + 1'b1;
          res_status_d    = vpa_pkg::ST_DONE;
          res_start_d     = pick_start_q;
          state_d         = vpa_pkg::S_RESULT;
        end else begin
          rd_idx    = idx_q[vpa_pkg::IDX_W-1:0] - 1'b1;
          wr_a.en   = 1'b1;
          wr_a.idx  = idx_q[vpa_pkg::IDX_W-1:0];
          wr_a.data = rd_data;
          idx_d     = idx_q - 1'b1;
        end
      end
      vpa_pkg::S_FREE: begin
        // release and merge in one pass, acc holds the open block
        if (idx_q == count_q) begin
          wr_a.en      = 1'b1;
          wr_a.idx     = wr_q[vpa_pkg::IDX_W-1:0];
          wr_a.data    = acc_q;
          count_d      = wr_q + 1'b1;
          res_status_d = vpa_pkg::ST_DONE;
          res_start_d  = '0;
          state_d      = vpa_pkg::S_RESULT;
        end else begin
          idx_d = idx_q + 1'b1;
          if (acc_vld_q && acc_q.free && freed) begin
            acc_d.size = acc_q.size + rd_data.size;
          end else begin
            if (acc_vld_q) begin
              wr_a.en   = 1'b1;
              wr_a.idx  = wr_q[vpa_pkg::IDX_W-1:0];
              wr_a.data = acc_q;
              wr_d      = wr_q + 1'b1;
            end
            acc_vld_d  = 1'b1;
            acc_d      = rd_data;
            acc_d.free = freed;
            if (!rd_data.free && freed) begin
              acc_d.owner = '0;
            end
          end
        end
      end
      vpa_pkg::S_RESULT: begin
        if (!out_stall_i) begin
          state_d = vpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = vpa_pkg::S_INIT;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vpa_pkg::S_INIT;
      total_q   <= 16'hFFFF;
      count_q   <= vpa_pkg::CNT_W'(1);
      idx_q     <= '0;
      wr_q      <= '0;
      found_q   <= 1'b0;
      acc_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      wr_q      <= wr_d;
      found_q   <= found_d;
      acc_vld_q <= acc_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_q        <= req_d;
    own_q        <= own_d;
    pick_q       <= pick_d;
    pick_size_q  <= pick_size_d;
    pick_start_q <= pick_start_d;
    acc_q        <= acc_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
  end

endmodule
`default_nettype wire

### src/vpa_fit.sv
// vpa_fit: shared compare unit, checks one entry against the request and the current pick
// depends on vpa_pkg
`default_nettype none
module vpa_fit (
  input  wire vpa_pkg::op_e               op_i,
  input  wire vpa_pkg::entry_t            entry_i,
  input  wire logic [vpa_pkg::ADDR_W-1:0] req_i,
  input  wire logic [vpa_pkg::ADDR_W-1:0] pick_size_i,
  output logic                            fit_o,
  output logic                            better_o
);

  // entry can hold the request
  assign fit_o = entry_i.free && (req_i != '0) && (entry_i.size >= req_i);

  // strictly better than the current pick, ties keep the lower address
  always_comb begin
    case (op_i)
      vpa_pkg::OP_BEST:  better_o = entry_i.size < pick_size_i;
      vpa_pkg::OP_WORST: better_o = entry_i.size > pick_size_i;
      default:           better_o = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

### src/vpa_table.sv
// vpa_table: block table registers, one read address and two write ports
// depends on vpa_pkg
`default_nettype none
module vpa_table (
  input  wire                             clk_i,
  input  wire logic [vpa_pkg::IDX_W-1:0]  rd_idx_i,
  output vpa_pkg::entry_t                 rd_data_o,
  input  wire vpa_pkg::tbl_wr_t           wr_a_i,
  input  wire vpa_pkg::tbl_wr_t           wr_b_i
);

  vpa_pkg::entry_t mem_q [vpa_pkg::MAX_BLOCKS];

  // read at one address
  assign rd_data_o = mem_q[rd_idx_i];

  // port b wins on a clash, never happens in use
  always_ff @(posedge clk_i) begin
    if (wr_a_i.en) begin
      mem_q[wr_a_i.idx] <= wr_a_i.data;
    end
    if (wr_b_i.en) begin
      mem_q[wr_b_i.idx] <= wr_b_i.data;
    end
  end

endmodule
`default_nettype wire

### test/tb.sv
// tb: self-checking testbench of variable_partition_allocator
// depends on vpa_pkg and the variable_partition_allocator rtl
`timescale 1ns / 1ps
module tb;

  localparam int WATCH_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [vpa_pkg::ADDR_W-1:0] total_memory_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = '0;
  logic [vpa_pkg::ADDR_W-1:0] request_size_i = '0;
  logic [vpa_pkg::OWNER_W-1:0] owner_id_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [vpa_pkg::ADDR_W-1:0] alloc_start_o;

  variable_partition_allocator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .total_memory_i(total_memory_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .operation_i(operation_i), .request_size_i(request_size_i), .owner_id_i(owner_id_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(status_o), .alloc_start_o(alloc_start_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct packed {
    vpa_pkg::op_e op;
    logic [vpa_pkg::ADDR_W-1:0] size;
    logic [vpa_pkg::OWNER_W-1:0] owner;
  } request_t;

  typedef struct packed {
    vpa_pkg::status_e status;
    logic [vpa_pkg::ADDR_W-1:0] start;
  } answer_t;

  // shadow block table
  vpa_pkg::entry_t blk[vpa_pkg::MAX_BLOCKS];
  int blk_count;

  request_t pending_q[$];
  answer_t answer_q[$];
  int errors = 0;
  int sent = 0;
  int got = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  bit hold_send = 1'b0;
  bit [3:0] op_seen = '0;

  task automatic table_reset(input logic [vpa_pkg::ADDR_W-1:0] mem);
    for (int i = 0; i < vpa_pkg::MAX_BLOCKS; i++) blk[i] = '0;
    blk[0].size = mem;
    blk[0].free = 1'b1;
    blk_count = 1;
  endtask

  // append one request to the pending list
  task automatic queue_request(input request_t r);
    pending_q = {pending_q, r};
  endtask

  // allocate or free against the shadow table
  function automatic answer_t allocate_or_free(input request_t r);
    answer_t a;
    int pick;
    bit found;
    int wr;
    a = '{vpa_pkg::ST_DONE, '0};
    pick = 0;
    found = 1'b0;
    if (r.op == vpa_pkg::OP_FREE) begin
      for (int i = 0; i < blk_count; i++)
        if (!blk[i].free && blk[i].owner == r.owner) begin
          blk[i].free = 1'b1;
          blk[i].owner = '0;
        end
      wr = 0;
      for (int rd = 0; rd < blk_count; rd++) begin
        if (wr > 0 && blk[wr-1].free && blk[rd].free) blk[wr-1].size += blk[rd].size;
        else begin
          blk[wr] = blk[rd];
          wr++;
        end
      end
      blk_count = wr;
      return a;
    end
    for (int i = 0; i < blk_count; i++) begin
      if (!blk[i].free || r.size == 0 || blk[i].size < r.size) continue;
      if (!found) begin
        pick = i;
        found = 1'b1;
        if (r.op == vpa_pkg::OP_FIRST) break;
      end else if (r.op == vpa_pkg::OP_BEST && blk[i].size < blk[pick].size) pick = i;
      else if (r.op == vpa_pkg::OP_WORST && blk[i].size > blk[pick].size) pick = i;
    end
    if (!found) begin
      a.status = vpa_pkg::ST_NOFIT;
      return a;
    end
    if (blk[pick].size == r.size) begin
      blk[pick].free = 1'b0;
      blk[pick].owner = r.owner;
    end else begin
      if (blk_count >= vpa_pkg::MAX_BLOCKS) begin
        a.status = vpa_pkg::ST_FULL;
        return a;
      end
      for (int j = blk_count; j > pick; j--) blk[j] = blk[j-1];
      blk[pick].size = r.size;
      blk[pick].free = 1'b0;
      blk[pick].owner = r.owner;
      blk[pick+1].start = blk[pick].start + r.size;
      blk[pick+1].size -= r.size;
      blk_count++;
    end
    a.start = blk[pick].start;
    return a;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("mismatch %s on result %0d: expected %0d got %0d", what, got, exp_v, got_v);
    errors++;
  endtask

  // driver: one request beat per accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        answer_q = {answer_q, allocate_or_free(request_t'{vpa_pkg::op_e'(operation_i),
                                                          request_size_i, owner_id_i})};
        op_seen[operation_i] = 1'b1;
        sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
          request_t r;
          r = pending_q.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= r.op;
          request_size_i <= r.size;
          owner_id_i <= r.owner;
        end else in_valid_i <= 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: progress watchdog, and check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("timeout: no progress for %0d cycles", WATCH_LIMIT);
        $display("FAIL variable_partition_allocator");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        got++;
        if (answer_q.size() == 0) begin
          $display("unexpected result beat %0d", got);
          errors++;
        end else begin
          answer_t e;
          e = answer_q.pop_front();
          if (status_o !== e.status) report_mismatch("status", e.status, status_o);
          if (alloc_start_o !== e.start) report_mismatch("alloc_start", e.start, alloc_start_o);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid_i || answer_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_memory(input logic [vpa_pkg::ADDR_W-1:0] mem);
    wait_drained();
    cfg_valid_i <= 1'b1;
    total_memory_i <= mem;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    table_reset(mem);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic request_t rand_request(input logic [vpa_pkg::ADDR_W-1:0] mem);
    request_t r;
    int k;
    k = $urandom_range(99);
    r.op = (k < 70) ? vpa_pkg::op_e'($urandom_range(2)) : vpa_pkg::OP_FREE;
    r.owner = ($urandom_range(9) == 0) ? vpa_pkg::OWNER_W'($urandom) :
              vpa_pkg::OWNER_W'($urandom_range(5));
    k = $urandom_range(19);
    if (k == 0) r.size = vpa_pkg::ADDR_W'($urandom);
    else if (k == 1) r.size = 0;
    else r.size = vpa_pkg::ADDR_W'($urandom_range(1, (mem / 24) + 1));
    return r;
  endfunction

  task automatic random_phase(input int n, input logic [vpa_pkg::ADDR_W-1:0] mem);
    for (int i = 0; i < n; i++) queue_request(rand_request(mem));
  endtask

  initial begin
    logic [vpa_pkg::ADDR_W-1:0] mem;
    table_reset(16'hFFFF);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: extremes, every op, exact fit, nofit, zero size, free of absent owner
    send_idle_pct = 23; recv_idle_pct = 63;
    write_memory(16'd100);
    queue_request('{vpa_pkg::OP_FIRST, 16'd0, 8'd1});
    queue_request('{vpa_pkg::OP_FIRST, 16'd30, 8'd1});
    queue_request('{vpa_pkg::OP_BEST, 16'd10, 8'd2});
    queue_request('{vpa_pkg::OP_WORST, 16'd20, 8'd3});
    queue_request('{vpa_pkg::OP_FREE, 16'd0, 8'd2});
    queue_request('{vpa_pkg::OP_BEST, 16'd10, 8'd255});
    queue_request('{vpa_pkg::OP_WORST, 16'hFFFF, 8'd0});
    queue_request('{vpa_pkg::OP_FIRST, 16'd40, 8'd4});
    queue_request('{vpa_pkg::OP_FREE, 16'hFFFF, 8'd99});
    queue_request('{vpa_pkg::OP_FREE, 16'd0, 8'd1});
    queue_request('{vpa_pkg::OP_FREE, 16'd0, 8'd3});
    queue_request('{vpa_pkg::OP_FREE, 16'd0, 8'd4});
    queue_request('{vpa_pkg::OP_FREE, 16'd0, 8'd255});
    queue_request('{vpa_pkg::OP_FIRST, 16'd100, 8'd7});
    wait_drained();
    // fill the table with splits until full
    write_memory(16'd64);
    for (int i = 0; i < 34; i++) queue_request('{vpa_pkg::OP_FIRST, 16'd1, 8'(i)});
    write_memory(16'd0);
    queue_request('{vpa_pkg::OP_WORST, 16'd1, 8'd0});
    queue_request('{vpa_pkg::OP_FREE, 16'd0, 8'd0});

    // random phases with several memory sizes
    write_memory(16'hFFFF);
    random_phase(300, 16'hFFFF);
    wait_drained();
    hold_send = 1'b1;
    random_phase(50, 16'hFFFF);
    while (answer_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    hold_send = 1'b0;
    send_idle_pct = 63; recv_idle_pct = 23;
    write_memory(16'd1);
    random_phase(100, 16'd1);
    mem = vpa_pkg::ADDR_W'($urandom_range(200, 4000));
    write_memory(mem);
    random_phase(250, mem);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_memory(16'd500);
    random_phase(250, 16'd500);
    write_memory(16'hFFFF);
    random_phase(200, 16'hFFFF);
    wait_drained();

    $display("covered %0d requests, %0d results, op mask %b, several memory sizes",
             sent, got, op_seen);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("PASS variable_partition_allocator");
    end else begin
      $display("errors %0d, left over %0d", errors, answer_q.size());
      $display("FAIL variable_partition_allocator");
    end
    $finish;
  end
endmodule
